/* rtl/hcbd_pkg.sv */
// hcbd_pkg: shared types and codes for the http chunked body decoder
// no dependencies; used by the channel interfaces and the top level

package hcbd_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned MODE_W   = 2;
   localparam int unsigned LENGTH_W = 31;

   typedef logic [BYTE_W-1:0]   byte_type;
   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [LENGTH_W-1:0] length_type;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_BODY_MODE   = 1'b0,
      CSR_BODY_LENGTH = 1'b1
   } csr_index_type;

   // body framing modes (code 3 behaves as close mode)
   localparam mode_type MODE_CLOSE   = 2'd0;
   localparam mode_type MODE_LENGTH  = 2'd1;
   localparam mode_type MODE_CHUNKED = 2'd2;

   localparam byte_type CHAR_CR    = 8'h0D;
   localparam byte_type CHAR_LF    = 8'h0A;
   localparam byte_type CHAR_SPACE = 8'h20;
   localparam byte_type CHAR_TAB   = 8'h09;

endpackage

/* rtl/hcbd_ifs.sv */
// valid/ready channel interfaces for the http chunked body decoder
// depends on hcbd_pkg

interface hcbd_req_if;
   logic              valid;
   logic              ready;
   hcbd_pkg::byte_type in_byte;
   logic              start_of_body;
   logic              end_of_read;

   modport source (output valid, output in_byte, output start_of_body,
                   output end_of_read, input ready);
   modport sink   (input valid, input in_byte, input start_of_body,
                   input end_of_read, output ready);
endinterface

interface hcbd_rsp_if;
   logic              valid;
   logic              ready;
   hcbd_pkg::byte_type data_byte;
   logic              data_valid;
   logic              body_done;

   modport source (output valid, output data_byte, output data_valid,
                   output body_done, input ready);
   modport sink   (input valid, input data_byte, input data_valid,
                   input body_done, output ready);
endinterface

interface hcbd_csr_if;
   logic                     valid;
   logic                     ready;
   hcbd_pkg::csr_index_type  index;
   hcbd_pkg::length_type     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/http_chunked_body_decoder.sv */
// http_chunked_body_decoder: one body byte in, one result out per transfer
// latency: result is valid the cycle after the input transfer
// throughput: one byte per cycle; the single result register stalls the input
//   only while it holds a result that the sink does not take
// reset (synchronous, active high) clears the decoder state, the result valid
//   flag and both configuration registers
// depends on hcbd_pkg and hcbd_ifs

module http_chunked_body_decoder #(
   parameter int unsigned SIZE_BITS = 31
) (
   input  logic       clock,
   input  logic       reset,
   hcbd_req_if.sink   req_if,
   hcbd_rsp_if.source rsp_if,
   hcbd_csr_if.sink   csr_if
);
   import hcbd_pkg::*;

   localparam int unsigned ACC_W  = SIZE_BITS + 1;
   localparam int unsigned WIDE_W = SIZE_BITS + 5;
   localparam logic [ACC_W-1:0] ACC_SAT = {1'b1, {SIZE_BITS{1'b0}}};

   typedef enum logic [1:0] {
      PH_LINE,
      PH_DATA,
      PH_TRAIL1,
      PH_TRAIL2
   } phase_type;

   // configuration
   mode_type   body_mode_ff;
   length_type body_length_ff;

   // decoder state
   phase_type              phase_ff,         phase_in;
   logic [SIZE_BITS-1:0]   remaining_ff,     remaining_in;
   logic [ACC_W-1:0]       acc_ff,           acc_in;
   logic                   digit_seen_ff,    digit_seen_in;
   logic                   parse_stopped_ff, parse_stopped_in;
   logic                   last_was_cr_ff,   last_was_cr_in;
   length_type             counted_ff,       counted_in;
   logic                   finished_ff,      finished_in;

   // result register
   logic     rsp_valid_ff;
   byte_type rsp_byte_ff,  rsp_byte_in;
   logic     rsp_dvalid_ff, rsp_dvalid_in;
   logic     rsp_done_ff;

   // state after an optional start_of_body clear
   phase_type            cur_phase;
   logic [SIZE_BITS-1:0] cur_remaining;
   logic [ACC_W-1:0]     cur_acc;
   logic                 cur_digit, cur_stopped, cur_cr, cur_finished;
   length_type           cur_counted;

   logic     accept;
   byte_type b;

   function automatic logic is_hex(input byte_type c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [3:0] hex_val(input byte_type c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= "0" && c <= "9")      v = 4'(c - "0");
      else if (c >= "a" && c <= "f") v = 4'(c - "a" + 8'd10);
      else if (c >= "A" && c <= "F") v = 4'(c - "A" + 8'd10);
      return v;
   endfunction

   function automatic logic is_blank(input byte_type c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   assign accept        = req_if.valid && req_if.ready;
   assign req_if.ready  = !rsp_valid_ff || rsp_if.ready;
   assign csr_if.ready  = 1'b1;
   assign b             = req_if.in_byte;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.data_byte  = rsp_byte_ff;
   assign rsp_if.data_valid = rsp_dvalid_ff;
   assign rsp_if.body_done  = rsp_done_ff;

   always_comb begin
      if (req_if.start_of_body) begin
         cur_phase     = PH_LINE;
         cur_remaining = '0;
         cur_acc       = '0;
         cur_digit     = 1'b0;
         cur_stopped   = 1'b0;
         cur_cr        = 1'b0;
         cur_counted   = '0;
         cur_finished  = 1'b0;
      end else begin
         cur_phase     = phase_ff;
         cur_remaining = remaining_ff;
         cur_acc       = acc_ff;
         cur_digit     = digit_seen_ff;
         cur_stopped   = parse_stopped_ff;
         cur_cr        = last_was_cr_ff;
         cur_counted   = counted_ff;
         cur_finished  = finished_ff;
      end
   end

   always_comb begin
      logic [WIDE_W-1:0] acc_wide;
      logic              consumed;
      phase_in         = cur_phase;
      remaining_in     = cur_remaining;
      acc_in           = cur_acc;
      digit_seen_in    = cur_digit;
      parse_stopped_in = cur_stopped;
      last_was_cr_in   = cur_cr;
      counted_in       = cur_counted;
      finished_in      = cur_finished;
      rsp_dvalid_in    = 1'b0;
      acc_wide         = '0;
      consumed         = 1'b0;

      if (!cur_finished) begin
         case (body_mode_ff)
            MODE_CHUNKED: begin
               case (cur_phase)
                  PH_DATA: begin
                     rsp_dvalid_in = 1'b1;
                     if (cur_remaining != '0)
                        remaining_in = cur_remaining - SIZE_BITS'(1);
                     if (remaining_in == '0)
                        phase_in = PH_TRAIL1;
                  end
                  PH_TRAIL1: begin
                     phase_in = PH_TRAIL2;
                  end
                  PH_TRAIL2: begin
                     phase_in         = PH_LINE;
                     acc_in           = '0;
                     digit_seen_in    = 1'b0;
                     parse_stopped_in = 1'b0;
                     last_was_cr_in   = 1'b0;
                  end
                  default: begin
                     phase_in = PH_LINE;
                     if (cur_cr) begin
                        last_was_cr_in = 1'b0;
                        if (b == CHAR_LF) begin
                           // crlf closes the size line
                           consumed = 1'b1;
                           if (cur_digit && !cur_acc[SIZE_BITS]) begin
                              if (cur_acc == '0) begin
                                 finished_in = 1'b1;
                              end else begin
                                 remaining_in = cur_acc[SIZE_BITS-1:0];
                                 phase_in     = PH_DATA;
                              end
                           end
                           acc_in           = '0;
                           digit_seen_in    = 1'b0;
                           parse_stopped_in = 1'b0;
                        end else if (cur_digit) begin
                           // lone cr after a digit ends the number
                           parse_stopped_in = 1'b1;
                        end
                     end
                     if (!consumed) begin
                        if (b == CHAR_CR) begin
                           last_was_cr_in = 1'b1;
                        end else if (!parse_stopped_in) begin
                           if (is_hex(b)) begin
                              acc_wide = {cur_acc, 4'b0000} | WIDE_W'(hex_val(b));
                              if (|acc_wide[WIDE_W-1:SIZE_BITS])
                                 acc_in = ACC_SAT;
                              else
                                 acc_in = acc_wide[ACC_W-1:0];
                              digit_seen_in = 1'b1;
                           end else if (!(!digit_seen_in && is_blank(b))) begin
                              parse_stopped_in = 1'b1;
                           end
                        end
                     end
                  end
               endcase
            end
            MODE_LENGTH: begin
               if (cur_counted >= body_length_ff) begin
                  finished_in = 1'b1;
               end else begin
                  // count stays below body_length, so no wrap
                  rsp_dvalid_in = 1'b1;
                  counted_in    = cur_counted + LENGTH_W'(1);
                  if (counted_in >= body_length_ff)
                     finished_in = 1'b1;
               end
            end
            default: begin
               rsp_dvalid_in = 1'b1;
            end
         endcase
      end

      rsp_byte_in = rsp_dvalid_in ? b : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         body_mode_ff     <= MODE_CLOSE;
         body_length_ff   <= '0;
         phase_ff         <= PH_LINE;
         remaining_ff     <= '0;
         acc_ff           <= '0;
         digit_seen_ff    <= 1'b0;
         parse_stopped_ff <= 1'b0;
         last_was_cr_ff   <= 1'b0;
         counted_ff       <= '0;
         finished_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_if.valid) begin
            case (csr_if.index)
               CSR_BODY_MODE:   body_mode_ff   <= csr_if.data[MODE_W-1:0];
               CSR_BODY_LENGTH: body_length_ff <= csr_if.data;
               default:         body_mode_ff   <= body_mode_ff;
            endcase
         end
         if (accept) begin
            phase_ff         <= phase_in;
            remaining_ff     <= remaining_in;
            acc_ff           <= acc_in;
            digit_seen_ff    <= digit_seen_in;
            parse_stopped_ff <= parse_stopped_in;
            last_was_cr_ff   <= last_was_cr_in;
            counted_ff       <= counted_in;
            finished_ff      <= finished_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_byte_ff   <= rsp_byte_in;
         rsp_dvalid_ff <= rsp_dvalid_in;
         rsp_done_ff   <= finished_in;
      end
   end

   a_data_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> remaining_ff != '0)
      else $error("data phase with empty chunk count");

   a_finished_drops: assert property (@(posedge clock) disable iff (reset)
      accept && finished_ff && !req_if.start_of_body
      |=> rsp_valid_ff && !rsp_dvalid_ff && rsp_done_ff)
      else $error("byte passed after body finished");

   a_close_passes: assert property (@(posedge clock) disable iff (reset)
      accept && req_if.start_of_body
         && body_mode_ff != MODE_LENGTH && body_mode_ff != MODE_CHUNKED
      |=> rsp_dvalid_ff && !rsp_done_ff)
      else $error("close mode did not pass first byte");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_if.ready |-> !req_if.ready)
      else $error("input taken while result register is held");

endmodule
